// ----- rtl/hsg_pkg.sv -----
package hsg_pkg;

    localparam int FRAC_BITS = 16;

    // largest term or gain, 2^63 - 1
    localparam logic [63:0] TERM_MAX = 64'h7FFF_FFFF_FFFF_FFFF;

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_NUM_FEATURES = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BINS_IN_USE  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_REG_LAMBDA   = 2'd2;

    typedef logic signed [63:0] gain_t;

    typedef struct packed {
        logic busy;      // an item is in the update stage
        logic scan_req;  // that item closes the final sample
    } hsg_acc_stat_t;

endpackage

// ----- rtl/hsg_if.sv -----
interface hsg_in_if;
    logic               valid;
    logic               ready;
    logic [7:0]         bin_index;
    logic signed [31:0] residual;
    logic [31:0]        weight;
    logic               last_sample;

    modport source (output valid, bin_index, residual, weight, last_sample, input ready);
    modport sink   (input valid, bin_index, residual, weight, last_sample, output ready);
endinterface

interface hsg_out_if;
    logic               valid;
    logic               ready;
    logic               found;
    logic [4:0]         best_feature;
    logic [7:0]         best_bin;
    logic signed [63:0] best_gain;

    modport source (output valid, found, best_feature, best_bin, best_gain, input ready);
    modport sink   (input valid, found, best_feature, best_bin, best_gain, output ready);
endinterface

interface hsg_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [31:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ----- rtl/histogram_split_gain_finder_unit.sv -----
// Histogram split-gain finder. Sample items stream in at one word per clock while
// idle, with the per-bin sums kept in one synchronous memory (read at accept,
// written back the next cycle, forwarded on a repeat hit). After the last feature
// word of a sample flagged last_sample, input stalls while a sequencer walks every
// split of every feature: per split point one memory read and two gain terms, each
// term a start, one square step per 16-bit digit, a range check and, unless that
// check ends it, 63 divide steps, then done; plus one term for the parent. The
// result word is then loaded once the output register is free, and a clearing
// sweep writes zero to all 2^(clog2(MAX_FEATURES)+clog2(MAX_BINS)) entries (8192
// at the defaults); the same sweep runs after reset. Input stalls during the
// sweep; configuration writes are taken at any time.
module histogram_split_gain_finder_unit import hsg_pkg::*; #(
    parameter int MAX_FEATURES = 32,
    parameter int MAX_BINS     = 256,
    parameter int SUM_WIDTH    = 48
) (
    input  logic       clk,
    input  logic       rst_n,
    hsg_in_if.sink     in_ch,
    hsg_out_if.source  out_ch,
    hsg_cfg_if.sink    cfg
);

    localparam int FEAT_W = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1;
    localparam int BIN_W  = $clog2(MAX_BINS);
    localparam int ADDR_W = FEAT_W + BIN_W;
    localparam int FC_W   = $clog2(MAX_FEATURES + 1);
    localparam int BC_W   = $clog2(MAX_BINS + 1);
    localparam int ENT_W  = 2 * SUM_WIDTH;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_PS   = 4'd1;
    localparam logic [3:0] S_PW   = 4'd2;
    localparam logic [3:0] S_RD   = 4'd3;
    localparam logic [3:0] S_ACC  = 4'd4;
    localparam logic [3:0] S_LS   = 4'd5;
    localparam logic [3:0] S_LW   = 4'd6;
    localparam logic [3:0] S_RS   = 4'd7;
    localparam logic [3:0] S_RW   = 4'd8;
    localparam logic [3:0] S_GN   = 4'd9;
    localparam logic [3:0] S_UPD  = 4'd10;
    localparam logic [3:0] S_FIN  = 4'd11;
    localparam logic [3:0] S_CLR  = 4'd12;

    logic [5:0]           num_features_reg;
    logic [8:0]           bins_in_use_reg;
    logic [31:0]          reg_lambda_reg;

    logic [3:0]           state_reg;
    logic [FEAT_W-1:0]    f_reg;
    logic [BIN_W-1:0]     b_reg;
    logic [SUM_WIDTH-1:0] lg_reg;
    logic [SUM_WIDTH-1:0] lw_reg;
    logic [63:0]          parent_reg;
    logic [63:0]          tl_reg;
    logic [63:0]          tr_reg;
    gain_t                gain_reg;
    gain_t                best_reg;
    logic [FEAT_W-1:0]    bf_reg;
    logic [BIN_W-1:0]     bb_reg;
    logic                 found_reg;
    logic [ADDR_W-1:0]    clr_reg;

    logic                 out_valid_reg;
    logic                 out_found_reg;
    logic [4:0]           out_feature_reg;
    logic [7:0]           out_bin_reg;
    gain_t                out_gain_reg;

    logic [FC_W-1:0]      nf;
    logic [BC_W-1:0]      nb;
    hsg_acc_stat_t        acc_stat;
    logic                 clear_totals;
    logic                 acc_rd_en;
    logic [ADDR_W-1:0]    acc_rd_addr;
    logic                 acc_wr_en;
    logic [ADDR_W-1:0]    acc_wr_addr;
    logic [ENT_W-1:0]     acc_wr_data;
    logic [SUM_WIDTH-1:0] total_grad;
    logic [SUM_WIDTH-1:0] total_weight;

    logic                 mem_wr_en;
    logic [ADDR_W-1:0]    mem_wr_addr;
    logic [ENT_W-1:0]     mem_wr_data;
    logic                 mem_rd_en;
    logic [ADDR_W-1:0]    mem_rd_addr;
    logic [ENT_W-1:0]     mem_rd_data;

    logic                 term_start;
    logic [SUM_WIDTH-1:0] term_g;
    logic [SUM_WIDTH-1:0] term_w;
    logic                 term_done;
    logic [63:0]          term;

    logic [64:0]          lr_sum;
    logic [64:0]          lr_diff;
    gain_t                gain;
    logic                 last_bin;
    logic                 last_feat;

    // ---- configuration ----
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_features_reg <= 6'd1;
            bins_in_use_reg  <= 9'd256;
            reg_lambda_reg   <= 32'h0001_0000;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                CFG_NUM_FEATURES: num_features_reg <= cfg.data[5:0];
                CFG_BINS_IN_USE:  bins_in_use_reg  <= cfg.data[8:0];
                CFG_REG_LAMBDA:   reg_lambda_reg   <= cfg.data;
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        if (num_features_reg == 6'd0)
        begin
            nf = FC_W'(1);
        end
        else if (int'(num_features_reg) > MAX_FEATURES)
        begin
            nf = FC_W'(MAX_FEATURES);
        end
        else
        begin
            nf = FC_W'(num_features_reg);
        end
        nb = (int'(bins_in_use_reg) > MAX_BINS) ? BC_W'(MAX_BINS) : BC_W'(bins_in_use_reg);
    end

    // ---- accumulation ----
    hsg_accum #(
        .MAX_FEATURES (MAX_FEATURES),
        .MAX_BINS     (MAX_BINS),
        .SUM_WIDTH    (SUM_WIDTH)
    ) u_accum (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_ch        (in_ch),
        .enable       (state_reg == S_IDLE),
        .nf           (nf),
        .nb           (nb),
        .clear_totals (clear_totals),
        .rd_en        (acc_rd_en),
        .rd_addr      (acc_rd_addr),
        .rd_data      (mem_rd_data),
        .wr_en        (acc_wr_en),
        .wr_addr      (acc_wr_addr),
        .wr_data      (acc_wr_data),
        .total_grad   (total_grad),
        .total_weight (total_weight),
        .stat         (acc_stat)
    );

    assign mem_wr_en   = (state_reg == S_CLR) ? 1'b1 : acc_wr_en;
    assign mem_wr_addr = (state_reg == S_CLR) ? clr_reg : acc_wr_addr;
    assign mem_wr_data = (state_reg == S_CLR) ? '0 : acc_wr_data;
    assign mem_rd_en   = (state_reg == S_RD) ? 1'b1 : acc_rd_en;
    assign mem_rd_addr = (state_reg == S_RD) ? {f_reg, b_reg} : acc_rd_addr;

    hsg_hist_mem #(
        .ADDR_W (ADDR_W),
        .DATA_W (ENT_W)
    ) u_mem (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    // ---- gain terms ----
    always_comb
    begin
        term_start = 1'b0;
        term_g     = lg_reg;
        term_w     = lw_reg;
        unique case (state_reg)
            S_PS:
            begin
                term_start = 1'b1;
                term_g     = total_grad;
                term_w     = total_weight;
            end
            S_LS:
            begin
                term_start = 1'b1;
            end
            S_RS:
            begin
                term_start = 1'b1;
                term_g     = total_grad - lg_reg;
                term_w     = total_weight - lw_reg;
            end
            default:
            begin
                term_start = 1'b0;
            end
        endcase
    end

    hsg_term_unit #(
        .SUM_WIDTH (SUM_WIDTH)
    ) u_term (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (term_start),
        .g      (term_g),
        .w      (term_w),
        .lambda (reg_lambda_reg),
        .done   (term_done),
        .term   (term)
    );

    assign lr_sum  = {1'b0, tl_reg} + {1'b0, tr_reg};
    assign lr_diff = lr_sum - {1'b0, parent_reg};

    always_comb
    begin
        if (lr_sum >= {1'b0, parent_reg})
        begin
            gain = (lr_diff > {1'b0, TERM_MAX}) ? gain_t'(TERM_MAX) : gain_t'(lr_diff[63:0]);
        end
        else
        begin
            gain = gain_t'(64'd0 - (parent_reg - lr_sum[63:0]));
        end
    end

    assign last_bin  = (BC_W'(b_reg) + BC_W'(2)) >= nb;
    assign last_feat = (FC_W'(f_reg) + FC_W'(1)) >= nf;
    assign clear_totals = (state_reg == S_FIN) && !out_valid_reg;

    // ---- scan sequencer ----
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLR;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (acc_stat.scan_req)
                    begin
                        state_reg <= S_PS;
                    end
                end
                S_PS:  state_reg <= S_PW;
                S_PW:
                begin
                    if (term_done)
                    begin
                        state_reg <= (nb < BC_W'(2)) ? S_FIN : S_RD;
                    end
                end
                S_RD:  state_reg <= S_ACC;
                S_ACC: state_reg <= S_LS;
                S_LS:  state_reg <= S_LW;
                S_LW:
                begin
                    if (term_done)
                    begin
                        state_reg <= S_RS;
                    end
                end
                S_RS:  state_reg <= S_RW;
                S_RW:
                begin
                    if (term_done)
                    begin
                        state_reg <= S_GN;
                    end
                end
                S_GN:  state_reg <= S_UPD;
                S_UPD: state_reg <= (last_bin && last_feat) ? S_FIN : S_RD;
                S_FIN:
                begin
                    if (!out_valid_reg)
                    begin
                        out_valid_reg <= 1'b1;
                        clr_reg       <= '0;
                        state_reg     <= S_CLR;
                    end
                end
                S_CLR:
                begin
                    clr_reg <= clr_reg + ADDR_W'(1);
                    if (clr_reg == '1)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_IDLE:
            begin
                f_reg     <= '0;
                b_reg     <= '0;
                lg_reg    <= '0;
                lw_reg    <= '0;
                found_reg <= 1'b0;
                best_reg  <= '0;
                bf_reg    <= '0;
                bb_reg    <= '0;
            end
            S_PW:
            begin
                if (term_done)
                begin
                    parent_reg <= term;
                end
            end
            S_ACC:
            begin
                lg_reg <= lg_reg + mem_rd_data[ENT_W-1:SUM_WIDTH];
                lw_reg <= lw_reg + mem_rd_data[SUM_WIDTH-1:0];
            end
            S_LW:
            begin
                if (term_done)
                begin
                    tl_reg <= term;
                end
            end
            S_RW:
            begin
                if (term_done)
                begin
                    tr_reg <= term;
                end
            end
            S_GN:
            begin
                gain_reg <= gain;
            end
            S_UPD:
            begin
                // strict compare keeps the earliest split on ties
                if (!found_reg || gain_reg > best_reg)
                begin
                    found_reg <= 1'b1;
                    best_reg  <= gain_reg;
                    bf_reg    <= f_reg;
                    bb_reg    <= b_reg;
                end
                if (last_bin)
                begin
                    f_reg  <= f_reg + FEAT_W'(1);
                    b_reg  <= '0;
                    lg_reg <= '0;
                    lw_reg <= '0;
                end
                else
                begin
                    b_reg <= b_reg + BIN_W'(1);
                end
            end
            S_FIN:
            begin
                if (!out_valid_reg)
                begin
                    out_found_reg   <= found_reg;
                    out_feature_reg <= 5'(bf_reg);
                    out_bin_reg     <= 8'(bb_reg);
                    out_gain_reg    <= best_reg;
                end
            end
            default:
            begin
                gain_reg <= gain_reg;
            end
        endcase
    end

    assign out_ch.valid        = out_valid_reg;
    assign out_ch.found        = out_found_reg;
    assign out_ch.best_feature = out_feature_reg;
    assign out_ch.best_bin     = out_bin_reg;
    assign out_ch.best_gain    = out_gain_reg;

    a_no_input_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> !in_ch.ready)
        else $error("input accepted while scanning or clearing");

    a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FIN && !out_valid_reg) |=> (out_ch.valid && state_reg == S_CLR))
        else $error("result word not presented after scan");

    a_term_done_expected: assert property (@(posedge clk) disable iff (!rst_n)
        term_done |-> (state_reg == S_PW || state_reg == S_LW || state_reg == S_RW))
        else $error("gain term finished outside a wait state");

    a_scan_after_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_PS) |-> !acc_stat.busy)
        else $error("scan started with an update still in flight");

endmodule

// ----- rtl/hsg_hist_mem.sv -----
module hsg_hist_mem #(
    parameter int ADDR_W = 13,
    parameter int DATA_W = 96
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [(1 << ADDR_W)];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- rtl/hsg_term_unit.sv -----
// floor(G^2 * 2^16 / (W + lambda)) in Q32.32, saturated; zero for a zero denominator.
// Square by 16-bit digits, then one quotient bit per cycle.
module hsg_term_unit import hsg_pkg::*; #(
    parameter int SUM_WIDTH = 48
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [SUM_WIDTH-1:0] g,
    input  logic [SUM_WIDTH-1:0] w,
    input  logic [31:0]          lambda,
    output logic                 done,
    output logic [63:0]          term
);

    localparam int DEN_W = SUM_WIDTH + 1;
    localparam int NDIG  = (SUM_WIDTH + 15) / 16;
    localparam int MP_W  = NDIG * 16;
    localparam int SQ_W  = MP_W + SUM_WIDTH;
    localparam int HI_W  = SQ_W - 47;
    localparam int CW    = (HI_W > DEN_W) ? HI_W : DEN_W;
    localparam int PP_W  = SUM_WIDTH + 16;

    localparam logic [1:0] T_IDLE = 2'd0;
    localparam logic [1:0] T_SQ   = 2'd1;
    localparam logic [1:0] T_CHK  = 2'd2;
    localparam logic [1:0] T_DIV  = 2'd3;

    logic [1:0]           state_reg;
    logic [SUM_WIDTH-1:0] mag_reg;
    logic [MP_W-1:0]      dig_reg;
    logic [DEN_W-1:0]     den_reg;
    logic [SQ_W-1:0]      acc_reg;
    logic [5:0]           cnt_reg;
    logic [DEN_W-1:0]     rem_reg;
    logic [62:0]          lo_reg;
    logic [62:0]          q_reg;
    logic                 done_reg;
    logic [63:0]          term_reg;

    logic [SUM_WIDTH-1:0] mag_in;
    logic [PP_W-1:0]      pp;
    logic [HI_W-1:0]      hi;
    logic [DEN_W:0]       r2;
    logic                 r2_ge;
    logic [62:0]          q_next;

    assign mag_in = g[SUM_WIDTH-1] ? (SUM_WIDTH'(0) - g) : g;
    assign pp     = PP_W'(mag_reg) * PP_W'(dig_reg[MP_W-1 -: 16]);
    assign hi     = acc_reg[SQ_W-1:47];
    assign r2     = {rem_reg, lo_reg[62]};
    assign r2_ge  = r2 >= {1'b0, den_reg};
    assign q_next = {q_reg[61:0], r2_ge};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= T_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                T_IDLE:
                begin
                    if (start)
                    begin
                        state_reg <= T_SQ;
                    end
                end
                T_SQ:
                begin
                    if (cnt_reg == 6'd0)
                    begin
                        state_reg <= T_CHK;
                    end
                end
                T_CHK:
                begin
                    if (den_reg == '0 || CW'(hi) >= CW'(den_reg))
                    begin
                        state_reg <= T_IDLE;
                        done_reg  <= 1'b1;
                    end
                    else
                    begin
                        state_reg <= T_DIV;
                    end
                end
                T_DIV:
                begin
                    if (cnt_reg == 6'd0)
                    begin
                        state_reg <= T_IDLE;
                        done_reg  <= 1'b1;
                    end
                end
                default:
                begin
                    state_reg <= T_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            T_IDLE:
            begin
                mag_reg <= mag_in;
                dig_reg <= MP_W'(mag_in);
                den_reg <= {1'b0, w} + DEN_W'(lambda);
                acc_reg <= '0;
                cnt_reg <= 6'(NDIG - 1);
            end
            T_SQ:
            begin
                acc_reg <= SQ_W'({acc_reg, 16'b0}) + SQ_W'(pp);
                dig_reg <= {dig_reg[MP_W-17:0], 16'b0};
                cnt_reg <= cnt_reg - 6'd1;
            end
            T_CHK:
            begin
                if (den_reg == '0)
                begin
                    term_reg <= '0;
                end
                else if (CW'(hi) >= CW'(den_reg))
                begin
                    term_reg <= TERM_MAX;
                end
                rem_reg <= DEN_W'(hi);
                lo_reg  <= {acc_reg[46:0], 16'b0};
                q_reg   <= '0;
                cnt_reg <= 6'd62;
            end
            T_DIV:
            begin
                rem_reg <= r2_ge ? DEN_W'(r2 - {1'b0, den_reg}) : DEN_W'(r2);
                lo_reg  <= {lo_reg[61:0], 1'b0};
                q_reg   <= q_next;
                cnt_reg <= cnt_reg - 6'd1;
                term_reg <= {1'b0, q_next};
            end
            default:
            begin
                cnt_reg <= '0;
            end
        endcase
    end

    assign done = done_reg;
    assign term = term_reg;

endmodule

// ----- rtl/hsg_accum.sv -----
// Two-stage histogram update: read at accept, add and write back in the next cycle.
// A back-to-back hit on the entry just written takes the written word instead.
module hsg_accum import hsg_pkg::*; #(
    parameter int MAX_FEATURES = 32,
    parameter int MAX_BINS     = 256,
    parameter int SUM_WIDTH    = 48
) (
    input  logic                  clk,
    input  logic                  rst_n,
    hsg_in_if.sink                in_ch,
    input  logic                  enable,
    input  logic [$clog2(MAX_FEATURES+1)-1:0] nf,
    input  logic [$clog2(MAX_BINS+1)-1:0]     nb,
    input  logic                  clear_totals,
    output logic                  rd_en,
    output logic [((MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1)+$clog2(MAX_BINS)-1:0] rd_addr,
    input  logic [2*SUM_WIDTH-1:0] rd_data,
    output logic                  wr_en,
    output logic [((MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1)+$clog2(MAX_BINS)-1:0] wr_addr,
    output logic [2*SUM_WIDTH-1:0] wr_data,
    output logic [SUM_WIDTH-1:0]  total_grad,
    output logic [SUM_WIDTH-1:0]  total_weight,
    output hsg_acc_stat_t         stat
);

    localparam int FEAT_W = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1;
    localparam int BIN_W  = $clog2(MAX_BINS);
    localparam int ADDR_W = FEAT_W + BIN_W;
    localparam int FC_W   = $clog2(MAX_FEATURES + 1);
    localparam int ENT_W  = 2 * SUM_WIDTH;
    localparam int PROD_W = (SUM_WIDTH + FRAC_BITS > 65) ? SUM_WIDTH + FRAC_BITS : 65;

    logic [FEAT_W-1:0]    pos_reg;
    logic                 s1_valid_reg;
    logic                 s1_hist_reg;
    logic                 s1_tot_reg;
    logic                 s1_scan_reg;
    logic [ADDR_W-1:0]    s1_addr_reg;
    logic signed [31:0]   s1_res_reg;
    logic [31:0]          s1_wt_reg;
    logic                 lw_valid_reg;
    logic [ADDR_W-1:0]    lw_addr_reg;
    logic [ENT_W-1:0]     lw_data_reg;
    logic [SUM_WIDTH-1:0] tg_reg;
    logic [SUM_WIDTH-1:0] tw_reg;

    logic                 accept;
    logic                 fin;
    logic                 hist_ok;
    logic signed [PROD_W-1:0] prod;
    logic [SUM_WIDTH-1:0] contrib;
    logic [SUM_WIDTH-1:0] wt_ext;
    logic [ENT_W-1:0]     base;
    logic [ENT_W-1:0]     upd;

    assign in_ch.ready = enable && !(s1_valid_reg && s1_scan_reg);
    assign accept      = in_ch.valid && in_ch.ready;

    assign fin     = ({1'b0, FC_W'(pos_reg)} + (FC_W+1)'(1)) >= {1'b0, nf};
    assign hist_ok = (FC_W'(pos_reg) < nf) && ({1'b0, in_ch.bin_index} < 9'(nb));

    assign rd_en   = accept;
    assign rd_addr = {pos_reg, in_ch.bin_index[BIN_W-1:0]};

    // exact product, then floor shift to Q16.16
    assign prod    = PROD_W'(s1_res_reg) * PROD_W'($signed({1'b0, s1_wt_reg}));
    assign contrib = prod[SUM_WIDTH+FRAC_BITS-1:FRAC_BITS];
    assign wt_ext  = SUM_WIDTH'(s1_wt_reg);

    assign base = (lw_valid_reg && lw_addr_reg == s1_addr_reg) ? lw_data_reg : rd_data;
    assign upd  = {base[ENT_W-1:SUM_WIDTH] + contrib, base[SUM_WIDTH-1:0] + wt_ext};

    assign wr_en   = s1_valid_reg && s1_hist_reg;
    assign wr_addr = s1_addr_reg;
    assign wr_data = upd;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg      <= '0;
            s1_valid_reg <= 1'b0;
            lw_valid_reg <= 1'b0;
            tg_reg       <= '0;
            tw_reg       <= '0;
        end
        else
        begin
            s1_valid_reg <= accept;
            lw_valid_reg <= wr_en;
            if (accept)
            begin
                pos_reg <= fin ? '0 : pos_reg + FEAT_W'(1);
            end
            if (clear_totals)
            begin
                tg_reg <= '0;
                tw_reg <= '0;
            end
            else if (s1_valid_reg && s1_tot_reg)
            begin
                tg_reg <= tg_reg + contrib;
                tw_reg <= tw_reg + wt_ext;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_hist_reg <= hist_ok;
            s1_tot_reg  <= (pos_reg == '0);
            s1_scan_reg <= fin && in_ch.last_sample;
            s1_addr_reg <= rd_addr;
            s1_res_reg  <= in_ch.residual;
            s1_wt_reg   <= in_ch.weight;
        end
        if (wr_en)
        begin
            lw_addr_reg <= wr_addr;
            lw_data_reg <= upd;
        end
    end

    assign total_grad     = tg_reg;
    assign total_weight   = tw_reg;
    assign stat.busy      = s1_valid_reg;
    assign stat.scan_req  = s1_valid_reg && s1_scan_reg;

endmodule

// ----- tb/hsg_tb_if.sv -----
`timescale 1ns / 1ps

// Channel interfaces come from the RTL (hsg_in_if, hsg_out_if, hsg_cfg_if).
// This file carries the shared word types for the bench.
package hsg_tb_pkg;

    typedef struct {
        logic [7:0]         bin_index;
        logic signed [31:0] residual;
        logic [31:0]        weight;
        logic               last_sample;
    } sample_word_t;

    typedef struct {
        logic               found;
        logic [4:0]         best_feature;
        logic [7:0]         best_bin;
        logic signed [63:0] best_gain;
    } split_word_t;

endpackage

// ----- tb/histogram_split_gain_finder_unit_tb.sv -----
`timescale 1ns / 1ps

module histogram_split_gain_finder_unit_tb;
    import hsg_pkg::*;
    import hsg_tb_pkg::*;

    localparam int NFEAT = 32;
    localparam int NBINS = 256;
    localparam longint CYCLE_LIMIT = 60000000;

    logic clk;
    logic rst_n;

    hsg_in_if  in_ch ();
    hsg_out_if out_ch ();
    hsg_cfg_if cfg ();

    histogram_split_gain_finder_unit u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .in_ch (in_ch),
        .out_ch(out_ch),
        .cfg   (cfg)
    );

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    // predictor state
    logic [47:0] grad_sum [NFEAT*NBINS];
    logic [47:0] wt_sum [NFEAT*NBINS];
    logic [47:0] grad_total;
    logic [47:0] wt_total;
    int unsigned feat_pos;
    logic [5:0]  nf_reg;
    logic [8:0]  bins_reg;
    logic [31:0] lambda_reg;

    sample_word_t word_q[$];
    split_word_t  split_q[$];
    int  errors;
    int  words_sent;
    longint cycles;
    logic in_took;
    int  in_gap;
    int  out_gap;
    bit  calm;

    task automatic report(input string what);
        errors++;
        $display("mismatch @%0t: %s", $realtime, what);
    endtask

    function automatic int eff_feats();
        if (nf_reg == 0)
            return 1;
        return (nf_reg > NFEAT) ? NFEAT : int'(nf_reg);
    endfunction

    function automatic int eff_bins();
        return (bins_reg > NBINS) ? NBINS : int'(bins_reg);
    endfunction

    function automatic logic [63:0] split_term(logic [47:0] g, logic [47:0] w);
        logic [47:0]  mag;
        logic [48:0]  den;
        logic [127:0] num;
        logic [127:0] q;
        mag = g[47] ? -g : g;
        den = {1'b0, w} + {17'b0, lambda_reg};
        if (den == 0)
            return 64'd0;
        num = {80'b0, mag} * {80'b0, mag};
        num = num << 16;
        q = num / {79'b0, den};
        if (q > {64'b0, TERM_MAX})
            return TERM_MAX;
        return q[63:0];
    endfunction

    function automatic logic signed [63:0] gain_of(logic [63:0] l, logic [63:0] r,
                                                   logic [63:0] p);
        logic [64:0] s;
        logic [64:0] d;
        s = {1'b0, l} + {1'b0, r};
        if (s >= {1'b0, p})
        begin
            d = s - {1'b0, p};
            return (d > {1'b0, TERM_MAX}) ? TERM_MAX : d[63:0];
        end
        return -$signed(p - s[63:0]);
    endfunction

    function automatic split_word_t best_split();
        split_word_t r;
        logic [63:0] parent;
        logic [47:0] lg;
        logic [47:0] lw;
        logic signed [63:0] g;
        int nf;
        int nb;
        nf = eff_feats();
        nb = eff_bins();
        parent = split_term(grad_total, wt_total);
        r = '{1'b0, 5'd0, 8'd0, 64'sd0};
        if (nb >= 2)
        begin
            for (int f = 0; f < nf; f++)
            begin
                lg = '0;
                lw = '0;
                for (int b = 0; b + 1 < nb; b++)
                begin
                    lg = lg + grad_sum[f*NBINS+b];
                    lw = lw + wt_sum[f*NBINS+b];
                    g = gain_of(split_term(lg, lw),
                                split_term(grad_total - lg, wt_total - lw), parent);
                    if (!r.found || g > r.best_gain)
                        r = '{1'b1, f[4:0], b[7:0], g};
                end
            end
        end
        return r;
    endfunction

    function automatic void clear_hist();
        foreach (grad_sum[i])
        begin
            grad_sum[i] = '0;
            wt_sum[i] = '0;
        end
        grad_total = '0;
        wt_total = '0;
        feat_pos = 0;
    endfunction

    // one accepted word into the histograms; may queue a split result
    function automatic void accumulate(sample_word_t w);
        logic signed [64:0] prod;
        logic signed [64:0] sh;
        logic [47:0] contrib;
        int nf;
        nf = eff_feats();
        prod = $signed(w.residual) * $signed({1'b0, w.weight});
        sh = prod >>> 16;
        contrib = sh[47:0];
        if (feat_pos == 0)
        begin
            grad_total = grad_total + contrib;
            wt_total = wt_total + {16'b0, w.weight};
        end
        if (feat_pos < nf && w.bin_index < eff_bins())
        begin
            grad_sum[feat_pos*NBINS+w.bin_index] += contrib;
            wt_sum[feat_pos*NBINS+w.bin_index] += {16'b0, w.weight};
        end
        if (feat_pos + 1 >= nf)
        begin
            feat_pos = 0;
            if (w.last_sample)
            begin
                split_q.insert(split_q.size(), best_split());
                clear_hist();
            end
        end
        else
            feat_pos++;
    endfunction

    function automatic int pick_gap();
        int r;
        if (calm)
            return 0;
        r = $urandom_range(99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(3, 1);
        return $urandom_range(40, 5);
    endfunction

    // monitor
    always @(posedge clk)
    begin
        split_word_t e;
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("histogram_split_gain_finder_unit_tb NOT OK");
            $finish;
        end
        in_took <= in_ch.valid && in_ch.ready;
        if (rst_n && in_ch.valid && in_ch.ready)
            accumulate('{in_ch.bin_index, in_ch.residual, in_ch.weight, in_ch.last_sample});
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (split_q.size() == 0)
                report("split result with none expected");
            else
            begin
                e = split_q.pop_front();
                if (out_ch.found !== e.found)
                    report($sformatf("found %0d exp %0d", out_ch.found, e.found));
                if (out_ch.best_feature !== e.best_feature)
                    report($sformatf("feature %0d exp %0d", out_ch.best_feature,
                                     e.best_feature));
                if (out_ch.best_bin !== e.best_bin)
                    report($sformatf("bin %0d exp %0d", out_ch.best_bin, e.best_bin));
                if (out_ch.best_gain !== e.best_gain)
                    report($sformatf("gain %h exp %h", out_ch.best_gain, e.best_gain));
            end
        end
    end

    // driver
    always @(negedge clk)
    begin
        sample_word_t w;
        if ($urandom_range(199) == 0)
            calm <= ~calm;
        if (rst_n)
        begin
            if (in_ch.valid && !in_took)
            begin
            end
            else if (in_gap > 0)
            begin
                in_ch.valid <= 1'b0;
                in_gap <= in_gap - 1;
            end
            else if (word_q.size() > 0)
            begin
                w = word_q.pop_front();
                in_ch.valid <= 1'b1;
                in_ch.bin_index <= w.bin_index;
                in_ch.residual <= w.residual;
                in_ch.weight <= w.weight;
                in_ch.last_sample <= w.last_sample;
                in_gap <= pick_gap();
            end
            else
                in_ch.valid <= 1'b0;

            if (out_gap > 0)
            begin
                out_ch.ready <= 1'b0;
                out_gap <= out_gap - 1;
            end
            else
            begin
                out_ch.ready <= 1'b1;
                out_gap <= pick_gap();
            end
        end
    end

    task automatic reg_write(input logic [1:0] idx, input logic [31:0] val);
        @(negedge clk);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data <= val;
        do
            @(posedge clk);
        while (!cfg.ready);
        case (idx)
            CFG_NUM_FEATURES: nf_reg = val[5:0];
            CFG_BINS_IN_USE:  bins_reg = val[8:0];
            CFG_REG_LAMBDA:   lambda_reg = val;
            default: ;
        endcase
        @(negedge clk);
        cfg.valid <= 1'b0;
    endtask

    task automatic setup(input logic [5:0] nf, input logic [8:0] nb, input logic [31:0] lam);
        reg_write(CFG_NUM_FEATURES, {26'b0, nf});
        reg_write(CFG_BINS_IN_USE, {23'b0, nb});
        reg_write(CFG_REG_LAMBDA, lam);
    endtask

    task automatic drain();
        do
            @(negedge clk);
        while (word_q.size() != 0 || in_ch.valid || split_q.size() != 0);
        repeat (200) @(posedge clk);
    endtask

    task automatic push(input logic [7:0] b, input logic [31:0] r, input logic [31:0] w,
                        input logic l);
        sample_word_t item;
        item = '{b, r, w, l};
        word_q.insert(word_q.size(), item);
        words_sent++;
    endtask

    function automatic logic [31:0] rand_res();
        case ($urandom_range(5))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return $urandom_range(200000);
            3: return -$urandom_range(200000);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [31:0] rand_wt();
        case ($urandom_range(5))
            0: return 32'd0;
            1: return 32'hFFFF_FFFF;
            2: return $urandom_range(300000);
            default: return $urandom;
        endcase
    endfunction

    // a run of whole samples, some words with out-of-range bins or stray flags, ending in a flagged final one
    task automatic push_set(input int samples);
        int nf;
        int nb;
        logic [7:0] b;
        logic [31:0] r;
        logic [31:0] w;
        nf = eff_feats();
        nb = eff_bins();
        for (int s = 0; s < samples; s++)
        begin
            r = rand_res();
            w = rand_wt();
            for (int f = 0; f < nf; f++)
            begin
                if (nb == 0 || $urandom_range(9) == 0)
                    b = 8'($urandom_range(255));
                else
                    b = 8'($urandom_range(nb - 1));
                push(b, r, w, (s == samples - 1) ? 1'b1 :
                     ($urandom_range(9) == 0 && f + 1 < nf));
            end
        end
    endtask

    initial
    begin
        int nfv;
        int nbv;
        logic [31:0] lam;
        errors = 0;
        words_sent = 0;
        cycles = 0;
        in_took = 1'b0;
        in_gap = 0;
        out_gap = 0;
        calm = 1'b0;
        nf_reg = 6'd1;
        bins_reg = 9'd256;
        lambda_reg = 32'd65536;
        clear_hist();
        in_ch.valid = 1'b0;
        in_ch.bin_index = '0;
        in_ch.residual = '0;
        in_ch.weight = '0;
        in_ch.last_sample = 1'b0;
        out_ch.ready = 1'b0;
        cfg.valid = 1'b0;
        cfg.index = '0;
        cfg.data = '0;
        rst_n = 1'b0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset settings, field extremes
        push(8'd0, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b0);
        push(8'd255, 32'h8000_0000, 32'hFFFF_FFFF, 1'b0);
        push(8'd3, 32'h8000_0000, 32'hFFFF_FFFF, 1'b1);
        drain();
        // too few bins: nothing found; zero features acts as one
        setup(6'd0, 9'd1, 32'd0);
        push(8'd0, 32'h0001_0000, 32'h0001_0000, 1'b1);
        drain();
        // zero lambda with zero weights: zero denominators, ties everywhere
        setup(6'd3, 9'd2, 32'd0);
        for (int i = 0; i < 6; i++)
            push(i[0] ? 8'd7 : 8'd1, 32'h0002_0000, 32'd0, i == 1 || i == 5);
        drain();
        // bins above the maximum, max lambda
        setup(6'd1, 9'd511, 32'hFFFF_FFFF);
        push(8'd254, 32'hFFFF_0000, 32'h0003_0000, 1'b0);
        push(8'd255, 32'h0005_0000, 32'h0001_0000, 1'b0);
        push(8'd128, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b1);
        drain();
        // features above the maximum act as the maximum
        setup(6'd63, 9'd2, 32'd65536);
        push_set(1);
        drain();

        while (words_sent < 1900)
        begin
            case ($urandom_range(9))
                0: nfv = 0;
                1: nfv = 32;
                default: nfv = $urandom_range(4, 1);
            endcase
            case ($urandom_range(9))
                0: nbv = $urandom_range(1);
                default: nbv = $urandom_range(6, 2);
            endcase
            case ($urandom_range(3))
                0: lam = 32'd0;
                1: lam = 32'hFFFF_FFFF;
                2: lam = 32'd65536;
                default: lam = $urandom;
            endcase
            setup(nfv[5:0], nbv[8:0], lam);
            repeat ($urandom_range(3, 1))
                push_set((nfv == 32) ? $urandom_range(3, 1) : $urandom_range(30, 5));
            drain();
        end

        if (errors == 0)
            $display("histogram_split_gain_finder_unit_tb OK");
        else
            $display("histogram_split_gain_finder_unit_tb NOT OK");
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/hsg_pkg.sv
rtl/hsg_if.sv
rtl/hsg_hist_mem.sv
rtl/hsg_term_unit.sv
rtl/hsg_accum.sv
rtl/histogram_split_gain_finder_unit.sv
tb/hsg_tb_if.sv
tb/histogram_split_gain_finder_unit_tb.sv
